### design/vn_pkg.sv
package vn_pkg;

  // Default component widths
  localparam int InWidth  = 32;
  localparam int OutWidth = 16;

endpackage

### design/vn_if.sv
// Input vector channel
interface vn_in_if #(
  parameter int IN_WIDTH = vn_pkg::InWidth
);
  logic                       valid;
  logic                       ready;
  logic signed [IN_WIDTH-1:0] x_in;
  logic signed [IN_WIDTH-1:0] y_in;
  logic signed [IN_WIDTH-1:0] z_in;

  modport source (output valid, output x_in, output y_in, output z_in, input ready);
  modport sink   (input valid, input x_in, input y_in, input z_in, output ready);
endinterface

// Result channel
interface vn_out_if #(
  parameter int IN_WIDTH  = vn_pkg::InWidth,
  parameter int OUT_WIDTH = vn_pkg::OutWidth
);
  logic                        valid;
  logic                        ready;
  logic signed [OUT_WIDTH-1:0] x_unit;
  logic signed [OUT_WIDTH-1:0] y_unit;
  logic signed [OUT_WIDTH-1:0] z_unit;
  logic        [IN_WIDTH-1:0]  magnitude;
  logic                        zero_vector;

  modport source (output valid, output x_unit, output y_unit, output z_unit,
                  output magnitude, output zero_vector, input ready);
  modport sink   (input valid, input x_unit, input y_unit, input z_unit,
                  input magnitude, input zero_vector, output ready);
endinterface

### design/vec3_normalize_unit.sv
// Vector normalize unit: takes one signed fixed-point 3D vector per transfer and returns
// its length (unsigned floor of the square root of the sum of squares, in the inputs'
// width and scale) and the unit vector in signed Q1.(OUT_WIDTH-1), truncated toward
// zero, with +1.0 saturated to the largest positive code. An all-zero vector gives zero
// outputs with zero_vector set. The pipeline accepts one vector every cycle while it is
// not held; it has four register stages for input, squares, sum and output,
// one stage per root bit and one stage per quotient bit. The whole pipeline holds
// while a finished result waits at the output.
module vec3_normalize_unit #(
  parameter int IN_WIDTH  = vn_pkg::InWidth,
  parameter int OUT_WIDTH = vn_pkg::OutWidth
) (
  input logic clk_i,
  input logic rst_ni,
  vn_in_if.sink    in_i,
  vn_out_if.source out_o
);

  localparam int N  = IN_WIDTH;
  localparam int SW = 2 * IN_WIDTH;
  localparam int OW = OUT_WIDTH;
  localparam int DW = IN_WIDTH + OUT_WIDTH - 1;

  logic adv;
  assign adv = !out_o.valid || out_o.ready;
  assign in_i.ready = adv;

  // Per-lane payload carried along the pipe
  logic [N-1:0] abs_q   [N+OW+3][3];
  logic [2:0]   neg_q   [N+OW+3];
  logic         zero_q  [N+OW+3];
  logic         vld_q   [N+OW+3];

  // Stage 0: input register, sign and magnitude split
  logic [N-1:0] in_raw [3];
  assign in_raw[0] = in_i.x_in;
  assign in_raw[1] = in_i.y_in;
  assign in_raw[2] = in_i.z_in;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q[0] <= 1'b0;
    end else if (adv) begin
      vld_q[0] <= in_i.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      for (int l = 0; l < 3; l++) begin
        neg_q[0][l] <= in_raw[l][N-1];
        abs_q[0][l] <= in_raw[l][N-1] ? (~in_raw[l] + N'(1)) : in_raw[l];
      end
      zero_q[0] <= 1'b0;
    end
  end

  // Stage 1: squares
  logic [SW-1:0] sq_q [3];
  always_ff @(posedge clk_i) begin
    if (adv) begin
      for (int l = 0; l < 3; l++) begin
        sq_q[l] <= SW'(abs_q[0][l]) * SW'(abs_q[0][l]);
      end
    end
  end

  // Stage 2: sum of squares and zero detect
  logic [SW-1:0] rem_q  [N+1];
  logic [N-1:0]  root_q [N+1];
  logic [SW-1:0] sum_d;
  assign sum_d = sq_q[0] + sq_q[1] + sq_q[2];

  always_ff @(posedge clk_i) begin
    if (adv) begin
      rem_q[0]  <= sum_d;
      root_q[0] <= '0;
    end
  end

  // Shared valid and payload shift for every stage after the input register
  for (genvar s = 1; s < N + OW + 3; s++) begin : g_carry
    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        vld_q[s] <= 1'b0;
      end else if (adv) begin
        vld_q[s] <= vld_q[s-1];
      end
    end

    always_ff @(posedge clk_i) begin
      if (adv) begin
        abs_q[s] <= abs_q[s-1];
        neg_q[s] <= neg_q[s-1];
        zero_q[s] <= (s == 2) ? (sum_d == '0) : zero_q[s-1];
      end
    end
  end

  // Square root: one root bit per stage, remainder holds sum - root^2
  for (genvar g = 0; g < N; g++) begin : g_sqrt
    localparam int K = N - 1 - g;
    logic [SW-1:0] trial;
    assign trial = (SW'(root_q[g]) << (K + 1)) + (SW'(1) << (2 * K));

    always_ff @(posedge clk_i) begin
      if (adv) begin
        if (rem_q[g] >= trial) begin
          rem_q[g+1]  <= rem_q[g] - trial;
          root_q[g+1] <= root_q[g] | (N'(1) << K);
        end else begin
          rem_q[g+1]  <= rem_q[g];
          root_q[g+1] <= root_q[g];
        end
      end
    end
  end

  // Division: one quotient bit per stage, three lanes side by side
  logic [DW-1:0] drem_q [1:OW][3];
  logic [OW-1:0] quo_q  [1:OW][3];
  logic [N-1:0]  mag_q  [1:OW];

  for (genvar j = 0; j < OW; j++) begin : g_div
    localparam int B = OW - 1 - j;
    logic [DW-1:0] rem_in [3];
    logic [OW-1:0] quo_in [3];
    logic [N-1:0]  mag_in;
    logic [DW-1:0] dv;

    // First stage starts from the root and the scaled components
    if (j == 0) begin : g_src
      always_comb begin
        for (int l = 0; l < 3; l++) begin
          rem_in[l] = DW'(abs_q[N+2][l]) << (OW - 1);
          quo_in[l] = '0;
        end
        mag_in = root_q[N];
      end
    end else begin : g_src
      always_comb begin
        rem_in = drem_q[j];
        quo_in = quo_q[j];
        mag_in = mag_q[j];
      end
    end

    assign dv = DW'(mag_in) << B;

    always_ff @(posedge clk_i) begin
      if (adv) begin
        mag_q[j+1] <= mag_in;
        for (int l = 0; l < 3; l++) begin
          if (rem_in[l] >= dv) begin
            drem_q[j+1][l] <= rem_in[l] - dv;
            quo_q[j+1][l]  <= quo_in[l] | (OW'(1) << B);
          end else begin
            drem_q[j+1][l] <= rem_in[l];
            quo_q[j+1][l]  <= quo_in[l];
          end
        end
      end
    end
  end

  // Output stage: sign, saturation at +1.0, zero-vector override
  localparam int LS = N + OW + 2;
  logic [OW-1:0] unit_d [3];
  logic [OW-1:0] unit_q [3];
  logic [N-1:0]  mag_out_q;
  logic          zero_out_q;
  logic          out_vld_q;

  always_comb begin
    for (int l = 0; l < 3; l++) begin
      if (zero_q[LS]) begin
        unit_d[l] = '0;
      end else if (neg_q[LS][l]) begin
        unit_d[l] = ~quo_q[OW][l] + OW'(1);
      end else if (quo_q[OW][l][OW-1]) begin
        unit_d[l] = {1'b0, {(OW-1){1'b1}}};
      end else begin
        unit_d[l] = quo_q[OW][l];
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_vld_q <= 1'b0;
    end else if (adv) begin
      out_vld_q <= vld_q[LS];
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      unit_q     <= unit_d;
      mag_out_q  <= zero_q[LS] ? '0 : mag_q[OW];
      zero_out_q <= zero_q[LS];
    end
  end

  assign out_o.valid       = out_vld_q;
  assign out_o.x_unit      = unit_q[0];
  assign out_o.y_unit      = unit_q[1];
  assign out_o.z_unit      = unit_q[2];
  assign out_o.magnitude   = mag_out_q;
  assign out_o.zero_vector = zero_out_q;

`ifndef ASSERT_OFF
  // Zero vector gives all-zero fields
  a_zero_fields: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_o.valid && out_o.zero_vector |-> out_o.magnitude == '0 &&
      out_o.x_unit == '0 && out_o.y_unit == '0 && out_o.z_unit == '0)
    else $error("zero vector with nonzero fields");

  // Any nonzero vector has a nonzero length
  a_nonzero_mag: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_o.valid && !out_o.zero_vector |-> out_o.magnitude != '0)
    else $error("nonzero vector with zero magnitude");

  // Pipe holds only while the output waits
  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !in_i.ready |-> out_o.valid && !out_o.ready)
    else $error("pipeline stalled without output backpressure");
`endif

endmodule
